// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, ignored during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/atapio_pkg.sv =====
`timescale 1ns / 1ps
package atapio_pkg;

   localparam int WORDS_PER_SECTOR = 256;
   localparam int SETTLE_READS     = 4;
   localparam int MAX_RES          = 8;

   localparam logic [28:0] POLL_RESET = 29'h1000_0000;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BUS   = 2'd1;
   localparam logic [1:0] OP_WORD  = 2'd2;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_IDENT = 2'd2;

   localparam logic [2:0] KIND_BUS_WR  = 3'd0;
   localparam logic [2:0] KIND_BUS_RD  = 3'd1;
   localparam logic [2:0] KIND_HOST_RD = 3'd2;
   localparam logic [2:0] KIND_WANT    = 3'd3;
   localparam logic [2:0] KIND_DONE    = 3'd4;

   localparam logic [3:0] REG_DATA   = 4'd0;
   localparam logic [3:0] REG_COUNT  = 4'd2;
   localparam logic [3:0] REG_LBA_LO = 4'd3;
   localparam logic [3:0] REG_LBA_MI = 4'd4;
   localparam logic [3:0] REG_LBA_HI = 4'd5;
   localparam logic [3:0] REG_DRIVE  = 4'd6;
   localparam logic [3:0] REG_STATUS = 4'd7;
   localparam logic [3:0] REG_ALT    = 4'd8;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BSY_TO   = 3'd1;
   localparam logic [2:0] ST_DRQ_TO   = 3'd2;
   localparam logic [2:0] ST_DEV_ERR  = 3'd3;
   localparam logic [2:0] ST_NO_DEV   = 3'd4;
   localparam logic [2:0] ST_PACKET   = 3'd5;
   localparam logic [2:0] ST_FLUSH_TO = 3'd6;

   localparam logic [7:0] SR_BSY = 8'h80;
   localparam logic [7:0] SR_DRQ = 8'h08;
   localparam logic [7:0] SR_ERR = 8'h01;

   localparam logic [15:0] ATA_READ  = 16'h0020;
   localparam logic [15:0] ATA_WRITE = 16'h0030;
   localparam logic [15:0] ATA_FLUSH = 16'h00E7;
   localparam logic [15:0] ATA_IDENT = 16'h00EC;

   typedef enum logic [4:0] {
      PH_IDLE, PH_PRE_BSY, PH_SET_SEL, PH_SET_CMD, PH_SEC_BSY, PH_SEC_DRQ,
      PH_RD_WORD, PH_WR_WORD, PH_SET_SECT, PH_FL_BSY0, PH_SET_FSEL,
      PH_SET_FCMD, PH_FL_BSY1, PH_ID_SET_SEL, PH_ID_SET_CMD, PH_ID_STATUS,
      PH_ID_BSY, PH_ID_MID, PH_ID_HI_CLEAN, PH_ID_HI_PKT, PH_ID_DRQ, PH_ID_WORD
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  command;
      logic        drive;
      logic [27:0] lba;
      logic [8:0]  sectors_left;
      logic [7:0]  word_index;
      logic [28:0] poll_count;
      logic [2:0]  settle_count;
   } state_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  reg_index;
      logic [15:0] bus_value;
      logic [2:0]  result_status;
   } res_type;

   function automatic res_type mk_res(logic [2:0] kind, logic [3:0] idx,
                                      logic [15:0] val, logic [2:0] st);
      res_type r;
      r.kind          = kind;
      r.reg_index     = idx;
      r.bus_value     = val;
      r.result_status = st;
      return r;
   endfunction

   function automatic logic [15:0] sel_value(logic drive, logic [3:0] head);
      return {8'h00, 8'hE0 | {3'b000, drive, 4'h0} | {4'h0, head}};
   endfunction

endpackage

// ===== rtl/core/ata_pio_host_sequencer.sv =====
`timescale 1ns / 1ps
// ATA PIO LBA28 host sequencer.
// req_ channel: one beat per host event. operation 0 starts a command (read,
// write or identify), 1 returns the data of the last requested register read,
// 2 hands over the next word to write. Beats that do not fit the current
// phase are dropped without any result.
// rsp_ channel: register writes, register read requests, host data words,
// word requests and a final done beat with its status; rsp_last marks the
// final beat produced by one req_ beat.
// csr_ channel: writes the poll limit, the number of status reads a wait
// may make before it gives up. Write it only while no command is in flight.
// Timing: a req_ beat is decoded in its accept cycle and its results are
// held in an eight-entry result buffer; the first appears in the next cycle
// and the rest follow one per cycle while rsp_ready is high. A beat has one
// to six results, and a dropped beat has none. req_ready rises again in the
// cycle the last buffered beat is taken, so beats follow back to back.
// A stalled rsp_ready holds the current beat and blocks new req_ beats.
// Reset (synchronous) empties the buffer, returns the sequencer to idle and
// sets the poll limit to 2^28.
module ata_pio_host_sequencer import atapio_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [1:0]  req_command,
   input  logic        req_drive,
   input  logic [27:0] req_lba,
   input  logic [7:0]  req_sector_count,
   input  logic [15:0] req_read_data,
   input  logic [15:0] req_write_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [3:0]  rsp_reg_index,
   output logic [15:0] rsp_bus_value,
   output logic [2:0]  rsp_result_status,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [28:0] csr_poll_limit
);

   state_type     state_ff, state_in;
   logic [28:0]   poll_limit_ff;
   res_type [7:0] buf_ff, buf_in;
   logic [3:0]    count_ff, count_in;
   logic [2:0]    rd_ff;
   logic [3:0]    step_count;
   logic          req_fire, rsp_fire, at_last;
   res_type       head;

   atapio_step u_step (
      .cur          (state_ff),
      .poll_limit   (poll_limit_ff),
      .operation    (req_operation),
      .command      (req_command),
      .drive        (req_drive),
      .lba          (req_lba),
      .sector_count (req_sector_count),
      .read_data    (req_read_data),
      .write_word   (req_write_word),
      .nxt          (state_in),
      .res          (buf_in),
      .res_count    (step_count)
   );

   assign head      = buf_ff[rd_ff];
   assign at_last   = {1'b0, rd_ff} == (count_ff - 4'd1);
   assign rsp_valid = count_ff != 4'd0;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign req_ready = !rsp_valid || (rsp_ready && at_last);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_kind          = head.kind;
   assign rsp_reg_index     = head.reg_index;
   assign rsp_bus_value     = head.bus_value;
   assign rsp_result_status = head.result_status;
   assign rsp_last          = at_last;

   always_comb begin
      count_in = count_ff;
      if (rsp_fire && at_last) count_in = 4'd0;
      if (req_fire) count_in = step_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '{phase: PH_IDLE, default: '0};
         poll_limit_ff <= POLL_RESET;
         count_ff      <= 4'd0;
         rd_ff         <= 3'd0;
      end else begin
         count_ff <= count_in;
         if (req_fire) begin
            state_ff <= state_in;
            rd_ff    <= 3'd0;
         end else if (rsp_fire) begin
            rd_ff <= rd_ff + 3'd1;
         end
         if (csr_valid) poll_limit_ff <= csr_poll_limit;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire) buf_ff <= buf_in;
   end

endmodule

// ===== rtl/core/atapio_step.sv =====
`timescale 1ns / 1ps
module atapio_step import atapio_pkg::*; (
   input  state_type       cur,
   input  logic [28:0]     poll_limit,
   input  logic [1:0]      operation,
   input  logic [1:0]      command,
   input  logic            drive,
   input  logic [27:0]     lba,
   input  logic [7:0]      sector_count,
   input  logic [15:0]     read_data,
   input  logic [15:0]     write_word,
   output state_type       nxt,
   output res_type [7:0]   res,
   output logic [3:0]      res_count
);

   logic [7:0]  b;
   logic        bsy, drq, err;
   logic        settle_last, word_last, expired, start_ok, bus_ok, word_ok;
   logic        settle_ph, bsy_ph;
   logic [28:0] poll_next;
   logic [8:0]  sect_next;
   logic [8:0]  cnt_full;
   logic [15:0] count_val;

   assign b           = read_data[7:0];
   assign bsy         = (b & SR_BSY) != 8'h00;
   assign drq         = (b & SR_DRQ) != 8'h00;
   assign err         = (b & SR_ERR) != 8'h00;
   assign settle_last = ({1'b0, cur.settle_count} + 4'd1) >= 4'(SETTLE_READS);
   assign word_last   = {1'b0, cur.word_index} >= 9'(WORDS_PER_SECTOR - 1);
   assign poll_next   = cur.poll_count + 29'd1;
   assign expired     = poll_next >= poll_limit;
   assign sect_next   = cur.sectors_left - 9'd1;
   assign cnt_full    = (sector_count == 8'h00) ? 9'd256 : {1'b0, sector_count};
   assign count_val   = (cur.sectors_left == 9'd256) ? 16'h0000
                                                     : {7'h00, cur.sectors_left};
   assign start_ok    = operation == OP_START && cur.phase == PH_IDLE
                        && command != 2'd3;
   assign bus_ok      = operation == OP_BUS && cur.phase != PH_WR_WORD;
   assign word_ok     = operation == OP_WORD && cur.phase == PH_WR_WORD;
   assign settle_ph   = cur.phase == PH_SET_SEL || cur.phase == PH_SET_CMD
                        || cur.phase == PH_SET_SECT || cur.phase == PH_SET_FSEL
                        || cur.phase == PH_SET_FCMD || cur.phase == PH_ID_SET_SEL
                        || cur.phase == PH_ID_SET_CMD;
   assign bsy_ph      = cur.phase == PH_PRE_BSY || cur.phase == PH_SEC_BSY
                        || cur.phase == PH_FL_BSY0 || cur.phase == PH_FL_BSY1
                        || cur.phase == PH_ID_BSY;

   // next state
   always_comb begin
      nxt = cur;
      if (start_ok) begin
         nxt.command      = command;
         nxt.drive        = drive;
         nxt.lba          = lba;
         nxt.sectors_left = cnt_full;
         nxt.word_index   = 8'h00;
         nxt.poll_count   = 29'd0;
         nxt.settle_count = 3'd0;
         nxt.phase        = (command == CMD_IDENT) ? PH_ID_SET_SEL : PH_PRE_BSY;
      end else if (word_ok) begin
         if (!word_last) begin
            nxt.word_index = cur.word_index + 8'd1;
         end else begin
            nxt.settle_count = 3'd0;
            nxt.phase        = PH_SET_SECT;
         end
      end else if (bus_ok) begin
         if (settle_ph) begin
            if (!settle_last) begin
               nxt.settle_count = cur.settle_count + 3'd1;
            end else begin
               case (cur.phase)
                  PH_SET_SEL: begin
                     nxt.settle_count = 3'd0;
                     nxt.phase        = PH_SET_CMD;
                  end
                  PH_SET_CMD: begin
                     nxt.poll_count = 29'd0;
                     nxt.phase      = PH_SEC_BSY;
                  end
                  PH_SET_SECT: begin
                     nxt.sectors_left = sect_next;
                     nxt.poll_count   = 29'd0;
                     if (sect_next != 9'd0) nxt.phase = PH_SEC_BSY;
                     else if (cur.command == CMD_READ) nxt.phase = PH_IDLE;
                     else nxt.phase = PH_FL_BSY0;
                  end
                  PH_SET_FSEL: begin
                     nxt.settle_count = 3'd0;
                     nxt.phase        = PH_SET_FCMD;
                  end
                  PH_SET_FCMD: begin
                     nxt.poll_count = 29'd0;
                     nxt.phase      = PH_FL_BSY1;
                  end
                  PH_ID_SET_SEL: begin
                     nxt.settle_count = 3'd0;
                     nxt.phase        = PH_ID_SET_CMD;
                  end
                  default: nxt.phase = PH_ID_STATUS;
               endcase
            end
         end else if (bsy_ph) begin
            if (bsy) begin
               nxt.poll_count = poll_next;
               if (expired) nxt.phase = PH_IDLE;
            end else begin
               nxt.settle_count = 3'd0;
               nxt.poll_count   = 29'd0;
               case (cur.phase)
                  PH_PRE_BSY: nxt.phase = PH_SET_SEL;
                  PH_SEC_BSY: nxt.phase = PH_SEC_DRQ;
                  PH_FL_BSY0: nxt.phase = PH_SET_FSEL;
                  PH_FL_BSY1: nxt.phase = PH_IDLE;
                  default:    begin
                     nxt.poll_count = cur.poll_count;
                     nxt.phase      = PH_ID_MID;
                  end
               endcase
            end
         end else begin
            case (cur.phase)
               PH_SEC_DRQ, PH_ID_DRQ: begin
                  if (err) begin
                     nxt.phase = PH_IDLE;
                  end else if (drq) begin
                     nxt.word_index = 8'h00;
                     if (cur.phase == PH_ID_DRQ) nxt.phase = PH_ID_WORD;
                     else if (cur.command == CMD_READ) nxt.phase = PH_RD_WORD;
                     else nxt.phase = PH_WR_WORD;
                  end else begin
                     nxt.poll_count = poll_next;
                     if (expired) nxt.phase = PH_IDLE;
                  end
               end
               PH_RD_WORD, PH_ID_WORD: begin
                  if (!word_last) begin
                     nxt.word_index = cur.word_index + 8'd1;
                  end else if (cur.phase == PH_ID_WORD) begin
                     nxt.phase = PH_IDLE;
                  end else begin
                     nxt.settle_count = 3'd0;
                     nxt.phase        = PH_SET_SECT;
                  end
               end
               PH_ID_STATUS: begin
                  nxt.poll_count = 29'd0;
                  nxt.phase      = (b == 8'h00) ? PH_IDLE : PH_ID_BSY;
               end
               PH_ID_MID: nxt.phase = (b != 8'h00) ? PH_ID_HI_PKT : PH_ID_HI_CLEAN;
               PH_ID_HI_CLEAN, PH_ID_HI_PKT: begin
                  nxt.poll_count = 29'd0;
                  if (cur.phase == PH_ID_HI_PKT || b != 8'h00) nxt.phase = PH_IDLE;
                  else nxt.phase = PH_ID_DRQ;
               end
               default: nxt.phase = cur.phase;
            endcase
         end
      end
   end

   // result list
   always_comb begin
      logic [3:0] n;
      n   = 4'd0;
      res = '0;
      if (start_ok) begin
         if (command == CMD_IDENT) begin
            res[n[2:0]] = mk_res(KIND_BUS_WR, REG_DRIVE, sel_value(drive, 4'h0), ST_OK);
            n = n + 4'd1;
            res[n[2:0]] = mk_res(KIND_BUS_RD, REG_ALT, 16'h0000, ST_OK);
            n = n + 4'd1;
         end else begin
            res[n[2:0]] = mk_res(KIND_BUS_RD, REG_STATUS, 16'h0000, ST_OK);
            n = n + 4'd1;
         end
      end else if (word_ok) begin
         res[n[2:0]] = mk_res(KIND_BUS_WR, REG_DATA, write_word, ST_OK);
         n = n + 4'd1;
         if (!word_last) res[n[2:0]] = mk_res(KIND_WANT, REG_DATA, 16'h0000, ST_OK);
         else res[n[2:0]] = mk_res(KIND_BUS_RD, REG_ALT, 16'h0000, ST_OK);
         n = n + 4'd1;
      end else if (bus_ok) begin
         if (settle_ph) begin
            if (!settle_last) begin
               res[n[2:0]] = mk_res(KIND_BUS_RD, REG_ALT, 16'h0000, ST_OK);
               n = n + 4'd1;
            end else begin
               case (cur.phase)
                  PH_SET_SEL, PH_ID_SET_SEL: begin
                     res[n[2:0]] = mk_res(KIND_BUS_WR, REG_COUNT,
                        (cur.phase == PH_SET_SEL) ? count_val : 16'h0000, ST_OK);
                     n = n + 4'd1;
                     res[n[2:0]] = mk_res(KIND_BUS_WR, REG_LBA_LO,
                        (cur.phase == PH_SET_SEL) ? {8'h00, cur.lba[7:0]} : 16'h0000,
                        ST_OK);
                     n = n + 4'd1;
                     res[n[2:0]] = mk_res(KIND_BUS_WR, REG_LBA_MI,
                        (cur.phase == PH_SET_SEL) ? {8'h00, cur.lba[15:8]} : 16'h0000,
                        ST_OK);
                     n = n + 4'd1;
                     res[n[2:0]] = mk_res(KIND_BUS_WR, REG_LBA_HI,
                        (cur.phase == PH_SET_SEL) ? {8'h00, cur.lba[23:16]} : 16'h0000,
                        ST_OK);
                     n = n + 4'd1;
                     res[n[2:0]] = mk_res(KIND_BUS_WR, REG_STATUS,
                        (cur.phase == PH_ID_SET_SEL) ? ATA_IDENT :
                        (cur.command == CMD_READ) ? ATA_READ : ATA_WRITE, ST_OK);
                     n = n + 4'd1;
                     res[n[2:0]] = mk_res(KIND_BUS_RD, REG_ALT, 16'h0000, ST_OK);
                     n = n + 4'd1;
                  end
                  PH_SET_SECT: begin
                     if (sect_next == 9'd0 && cur.command == CMD_READ)
                        res[n[2:0]] = mk_res(KIND_DONE, REG_DATA, 16'h0000, ST_OK);
                     else
                        res[n[2:0]] = mk_res(KIND_BUS_RD, REG_STATUS, 16'h0000, ST_OK);
                     n = n + 4'd1;
                  end
                  PH_SET_FSEL: begin
                     res[n[2:0]] = mk_res(KIND_BUS_WR, REG_STATUS, ATA_FLUSH, ST_OK);
                     n = n + 4'd1;
                     res[n[2:0]] = mk_res(KIND_BUS_RD, REG_ALT, 16'h0000, ST_OK);
                     n = n + 4'd1;
                  end
                  default: begin
                     res[n[2:0]] = mk_res(KIND_BUS_RD, REG_STATUS, 16'h0000, ST_OK);
                     n = n + 4'd1;
                  end
               endcase
            end
         end else if (bsy_ph) begin
            if (bsy) begin
               if (expired)
                  res[n[2:0]] = mk_res(KIND_DONE, REG_DATA, 16'h0000,
                     (cur.phase == PH_FL_BSY1) ? ST_FLUSH_TO : ST_BSY_TO);
               else
                  res[n[2:0]] = mk_res(KIND_BUS_RD, REG_STATUS, 16'h0000, ST_OK);
               n = n + 4'd1;
            end else begin
               case (cur.phase)
                  PH_PRE_BSY, PH_FL_BSY0: begin
                     res[n[2:0]] = mk_res(KIND_BUS_WR, REG_DRIVE, sel_value(cur.drive,
                        (cur.phase == PH_PRE_BSY) ? cur.lba[27:24] : 4'h0), ST_OK);
                     n = n + 4'd1;
                     res[n[2:0]] = mk_res(KIND_BUS_RD, REG_ALT, 16'h0000, ST_OK);
                     n = n + 4'd1;
                  end
                  PH_SEC_BSY: begin
                     res[n[2:0]] = mk_res(KIND_BUS_RD, REG_STATUS, 16'h0000, ST_OK);
                     n = n + 4'd1;
                  end
                  PH_FL_BSY1: begin
                     res[n[2:0]] = mk_res(KIND_DONE, REG_DATA, 16'h0000, ST_OK);
                     n = n + 4'd1;
                  end
                  default: begin
                     res[n[2:0]] = mk_res(KIND_BUS_RD, REG_LBA_MI, 16'h0000, ST_OK);
                     n = n + 4'd1;
                  end
               endcase
            end
         end else begin
            case (cur.phase)
               PH_SEC_DRQ, PH_ID_DRQ: begin
                  if (err)
                     res[n[2:0]] = mk_res(KIND_DONE, REG_DATA, 16'h0000, ST_DEV_ERR);
                  else if (drq && (cur.phase == PH_ID_DRQ || cur.command == CMD_READ))
                     res[n[2:0]] = mk_res(KIND_BUS_RD, REG_DATA, 16'h0000, ST_OK);
                  else if (drq)
                     res[n[2:0]] = mk_res(KIND_WANT, REG_DATA, 16'h0000, ST_OK);
                  else if (expired)
                     res[n[2:0]] = mk_res(KIND_DONE, REG_DATA, 16'h0000, ST_DRQ_TO);
                  else
                     res[n[2:0]] = mk_res(KIND_BUS_RD, REG_STATUS, 16'h0000, ST_OK);
                  n = n + 4'd1;
               end
               PH_RD_WORD, PH_ID_WORD: begin
                  res[n[2:0]] = mk_res(KIND_HOST_RD, REG_DATA, read_data, ST_OK);
                  n = n + 4'd1;
                  if (!word_last)
                     res[n[2:0]] = mk_res(KIND_BUS_RD, REG_DATA, 16'h0000, ST_OK);
                  else if (cur.phase == PH_ID_WORD)
                     res[n[2:0]] = mk_res(KIND_DONE, REG_DATA, 16'h0000, ST_OK);
                  else
                     res[n[2:0]] = mk_res(KIND_BUS_RD, REG_ALT, 16'h0000, ST_OK);
                  n = n + 4'd1;
               end
               PH_ID_STATUS: begin
                  if (b == 8'h00)
                     res[n[2:0]] = mk_res(KIND_DONE, REG_DATA, 16'h0000, ST_NO_DEV);
                  else
                     res[n[2:0]] = mk_res(KIND_BUS_RD, REG_STATUS, 16'h0000, ST_OK);
                  n = n + 4'd1;
               end
               PH_ID_MID: begin
                  res[n[2:0]] = mk_res(KIND_BUS_RD, REG_LBA_HI, 16'h0000, ST_OK);
                  n = n + 4'd1;
               end
               PH_ID_HI_CLEAN, PH_ID_HI_PKT: begin
                  if (cur.phase == PH_ID_HI_PKT || b != 8'h00)
                     res[n[2:0]] = mk_res(KIND_DONE, REG_DATA, 16'h0000, ST_PACKET);
                  else
                     res[n[2:0]] = mk_res(KIND_BUS_RD, REG_STATUS, 16'h0000, ST_OK);
                  n = n + 4'd1;
               end
               default: n = 4'd0;
            endcase
         end
      end
      res_count = n;
   end

endmodule

// ===== rtl/core/atapio_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module atapio_checker import atapio_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [15:0] rsp_bus_value,
   input logic [2:0]  rsp_result_status,
   input logic        rsp_last
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_bus_value))
   `ASSERT_IMPLY(a_done_last, clock, reset, rsp_valid && rsp_kind == KIND_DONE, rsp_last)
   `ASSERT_IMPLY(a_status_done, clock, reset, rsp_valid && rsp_kind != KIND_DONE, rsp_result_status == ST_OK)

endmodule

bind ata_pio_host_sequencer atapio_checker u_atapio_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_kind          (rsp_kind),
   .rsp_bus_value     (rsp_bus_value),
   .rsp_result_status (rsp_result_status),
   .rsp_last          (rsp_last)
);
